[rtl/spq_pkg.sv]
// Shared types and constants for the sorted priority queue.
// No dependencies; every other file imports this package.
package spq_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam int VAL_W  = 32;
  localparam int PRIO_W = 11;
  localparam int ACT_W  = 2;
  localparam int STAT_W = 2;

  localparam logic signed [PRIO_W-1:0] PRIO_CEIL = 11'sd999;

  // action codes
  localparam logic [ACT_W-1:0] ACT_PLAIN = 2'd0;
  localparam logic [ACT_W-1:0] ACT_PRIO  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_DEQ   = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE
  } cell_op_t;

  typedef struct packed {
    logic signed [VAL_W-1:0]  value;
    logic signed [PRIO_W-1:0] prio;
  } spq_slot_t;

  // broadcast to every cell
  typedef struct packed {
    cell_op_t  op;
    logic      plain;
    spq_slot_t item;
  } spq_cmd_t;

endpackage

[rtl/spq_if.sv]
// Valid/ready channel interfaces for the sorted priority queue.
// Depends on spq_pkg for field widths.
interface spq_in_if import spq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [ACT_W-1:0]         action;
  logic signed [VAL_W-1:0]  value;
  logic signed [PRIO_W-1:0] prio;

  modport source (output valid, action, value, prio, input ready);
  modport sink   (input valid, action, value, prio, output ready);
endinterface

interface spq_out_if import spq_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [STAT_W-1:0]       status;
  logic signed [VAL_W-1:0] out_value;
  logic [CNT_W-1:0]        occupancy;

  modport source (output valid, status, out_value, occupancy, input ready);
  modport sink   (input valid, status, out_value, occupancy, output ready);
endinterface

[rtl/sorted_priority_queue.sv]
// Sorted priority queue: a row of spq_cell slots kept in ascending priority.
// Depends on spq_pkg, spq_in_if / spq_out_if and spq_cell.
//
// Usage:
//   in_ch  carries one operation word: action (plain enqueue, priority
//          enqueue, dequeue), value and prio. A word is taken when valid and
//          ready are both high at a rising edge of clk.
//   out_ch returns exactly one word per operation: status (ok, full, empty),
//          out_value (dequeued value, else zero) and occupancy after it.
//   Latency: the result is valid on the cycle after the operation is taken.
//   Throughput: one operation per cycle if not stalled. Every slot compares
//   its priority with the new one at once and the insert point ripples along
//   the CAPACITY cells, so that chain sets the clock period, not the rate.
//   Stall: the result sits in an output register; in_ch.ready stays high
//   while that register is empty or being drained, so a stalled receiver
//   holds the input back after one pending word.
//   Reset (rst_n low, synchronous): the queue is emptied and the pending
//   result dropped; slot contents are not cleared and are never read
//   beyond the current occupancy.
module sorted_priority_queue import spq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  spq_in_if.sink    in_ch,
  spq_out_if.source out_ch
);

  logic [CNT_W-1:0]        count_r, count_nxt;
  logic                    out_valid_r;
  logic [STAT_W-1:0]       status_r, status_nxt;
  logic signed [VAL_W-1:0] value_r, value_nxt;

  logic                     accept;
  logic                     full, empty;
  logic signed [PRIO_W-1:0] prio_clamped;
  spq_cmd_t                 cmd;

  spq_slot_t            slots [CAPACITY];
  logic [CAPACITY:0]    after_chain;
  logic [CAPACITY-1:0]  occupied;

  assign in_ch.ready = ~out_valid_r | out_ch.ready;
  assign accept      = in_ch.valid & in_ch.ready;
  assign full        = count_r == CNT_W'(CAPACITY);
  assign empty       = count_r == '0;

  assign prio_clamped = (in_ch.prio > PRIO_CEIL) ? PRIO_CEIL : in_ch.prio;

  always_comb begin
    cmd.op         = CELL_HOLD;
    cmd.plain      = in_ch.action == ACT_PLAIN;
    cmd.item.value = in_ch.value;
    cmd.item.prio  = cmd.plain ? PRIO_CEIL : prio_clamped;
    count_nxt      = count_r;
    status_nxt     = ST_OK;
    value_nxt      = '0;
    case (in_ch.action)
      ACT_PLAIN, ACT_PRIO: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          cmd.op    = accept ? CELL_INSERT : CELL_HOLD;
          count_nxt = count_r + 1'b1;
        end
      end
      ACT_DEQ: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          cmd.op    = accept ? CELL_REMOVE : CELL_HOLD;
          value_nxt = slots[0].value;
          count_nxt = count_r - 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign after_chain[0] = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    spq_slot_t left_slot, right_slot;

    assign occupied[i] = count_r > CNT_W'(i);
    assign left_slot   = (i == 0) ? cmd.item : slots[(i == 0) ? 0 : i - 1];
    assign right_slot  = (i == CAPACITY - 1) ? slots[i]
                                             : slots[(i == CAPACITY - 1) ? i : i + 1];

    spq_cell u_cell (
      .clk        (clk),
      .head       (i == 0),
      .occupied   (occupied[i]),
      .cmd        (cmd),
      .after_in   (after_chain[i]),
      .left_slot  (left_slot),
      .right_slot (right_slot),
      .after_out  (after_chain[i+1]),
      .slot       (slots[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result word payload, loaded on acceptance
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      value_r  <= value_nxt;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.status    = status_r;
  assign out_ch.out_value = value_r;
  assign out_ch.occupancy = count_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("occupancy above capacity");

  a_deq_drops: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_ch.action == ACT_DEQ && !empty |=> count_r == $past(count_r) - 1'b1)
    else $error("dequeue did not drop occupancy");

  a_full_reject: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_ch.action == ACT_PLAIN || in_ch.action == ACT_PRIO) && full
    |=> status_r == ST_FULL && count_r == $past(count_r))
    else $error("enqueue into full queue not rejected");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && status_r == ST_EMPTY |-> value_r == '0 && count_r == '0)
    else $error("empty dequeue returned data");
`endif

endmodule

[rtl/spq_cell.sv]
// One slot of the sorted chain: holds a value and its priority.
// Depends on spq_pkg; instantiated in a row by sorted_priority_queue.
module spq_cell import spq_pkg::*; (
  input  logic      clk,
  input  logic      head,       // tied high on slot 0 only
  input  logic      occupied,
  input  spq_cmd_t  cmd,
  input  logic      after_in,   // insert point lies left of this slot
  input  spq_slot_t left_slot,
  input  spq_slot_t right_slot,
  output logic      after_out,  // insert point lies at or left of this slot
  output spq_slot_t slot
);

  spq_slot_t slot_r;
  spq_slot_t slot_nxt;
  logic      stop;

  // head is displaced only by a strictly lower priority; elsewhere ties go first
  always_comb begin
    if (cmd.plain) begin
      stop = 1'b0;
    end else if (head) begin
      stop = cmd.item.prio < slot_r.prio;
    end else begin
      stop = slot_r.prio >= cmd.item.prio;
    end
  end

  assign after_out = after_in | ~occupied | stop;

  always_comb begin
    slot_nxt = slot_r;
    case (cmd.op)
      CELL_INSERT: begin
        if (after_in) begin
          slot_nxt = left_slot;
        end else if (after_out) begin
          slot_nxt = cmd.item;
        end
      end
      CELL_REMOVE: slot_nxt = right_slot;
      default:     slot_nxt = slot_r;
    endcase
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
  end

  assign slot = slot_r;

endmodule
